// ===== design/pair_dedup_chain_table_unit_macros.svh =====
// Assertion macros for the pair dedup chain table unit.
// Used by the port checker; expects signals clk and rst in scope.
`ifndef PAIR_DEDUP_CHAIN_TABLE_UNIT_MACROS_SVH
`define PAIR_DEDUP_CHAIN_TABLE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDCT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdct: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PDCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdct: next-cycle check failed");

`endif

// ===== design/pdct_pkg.sv =====
// Shared types and defaults for the pair dedup chain table unit.
// No dependencies.
package pdct_pkg;

  localparam int DEPTH_DEF     = 4096;
  localparam int KEY_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_ADDED    = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_HEAD = 2'd3
  } status_t;

endpackage

// ===== design/pdct_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module pdct_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 76
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/pair_dedup_chain_table_unit.sv =====
// Top level of the pair dedup chain table unit: sequencer and entry count.
// Depends on pdct_pkg and pdct_ram.
//
// Usage: raise start with a head index and a key pair; the beat is taken on
// a cycle where busy is low. Exactly one result follows, shown on
// entry_index and status for a single cycle while done is high; the receiver
// cannot stall it, so capture it on that cycle. A bad head (above the entry
// count) is answered in the cycle after the beat. Otherwise the beat
// launches the read of the chain head, and the walk then visits the chain
// (the single read port of the entry RAM gives one entry a cycle); a miss
// at the chain end goes to an append state that writes the new entry, and a
// new chain goes straight to that append. On a full table a new chain is
// refused in the cycle after the beat, and a walk that reaches the chain end
// without a match is refused there. A new beat may be taken in the very
// cycle that done is shown. The RAM needs no clearing pass: only entries
// below the count are ever read.
module pair_dedup_chain_table_unit #(
  parameter int DEPTH     = pdct_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = pdct_pkg::KEY_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [$clog2(DEPTH):0]   head_index,
  input  logic [KEY_WIDTH-1:0]     first_key,
  input  logic [KEY_WIDTH-1:0]     second_key,
  output logic                     done,
  output logic [$clog2(DEPTH)-1:0] entry_index,
  output pdct_pkg::status_t        status
);

  import pdct_pkg::*;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W + 1;
  localparam int WORD_W = 2 * KEY_WIDTH + IDX_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_APPEND
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     count;
  logic [KEY_WIDTH-1:0] key_a;
  logic [KEY_WIDTH-1:0] key_b;
  logic [IDX_W-1:0]     cur_idx;

  // RAM port signals
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [WORD_W-1:0] rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_data;

  logic [KEY_WIDTH-1:0] rd_first;
  logic [KEY_WIDTH-1:0] rd_second;
  logic [IDX_W-1:0]     rd_link;

  logic head_bad;
  logic head_new;
  logic full;
  logic hit;
  logic link_end;

  // Entry word: first key on top, second key in the middle, link at the bottom.
  assign rd_first  = rd_data[WORD_W-1 -: KEY_WIDTH];
  assign rd_second = rd_data[IDX_W +: KEY_WIDTH];
  assign rd_link   = rd_data[IDX_W-1:0];

  assign busy     = (state != S_IDLE);
  assign head_bad = (head_index > count);
  assign head_new = (head_index == count);
  assign full     = (count == CNT_W'(DEPTH));
  assign hit      = (rd_first == key_a) && (rd_second == key_b);
  // A zero link closes the chain; entry 0 can only be a head.
  assign link_end = (rd_link == '0);

  // RAM address and enable steering. Reads and writes never touch the same
  // entry in overlapping cycles: the tail link is written only once the walk
  // has stopped reading, and the next beat waits until the append is done.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_index[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = {rd_first, rd_second, count[IDX_W-1:0]};
    unique case (state)
      S_IDLE: begin
        // Launch the read of the chain head with the beat.
        rd_en = start && !head_bad && !head_new;
      end
      S_WALK: begin
        // Advance along the link, or relink the tail to the new entry.
        rd_addr = rd_link;
        rd_en   = !hit && !link_end;
        wr_en   = !hit && link_end && !full;
      end
      S_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = count[IDX_W-1:0];
        wr_data = {key_a, key_b, {IDX_W{1'b0}}};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  pdct_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer, entry count and the registered result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key_a   <= first_key;
            key_b   <= second_key;
            cur_idx <= head_index[IDX_W-1:0];
            priority if (head_bad) begin
              // Drop the beat: state stays untouched.
              done        <= 1'b1;
              entry_index <= '0;
              status      <= ST_BAD_HEAD;
            end else if (head_new) begin
              if (full) begin
                done        <= 1'b1;
                entry_index <= '0;
                status      <= ST_FULL;
              end else begin
                state <= S_APPEND;
              end
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          priority if (hit) begin
            done        <= 1'b1;
            entry_index <= cur_idx;
            status      <= ST_FOUND;
            state       <= S_IDLE;
          end else if (!link_end) begin
            cur_idx <= rd_link;
          end else if (full) begin
            done        <= 1'b1;
            entry_index <= '0;
            status      <= ST_FULL;
            state       <= S_IDLE;
          end else begin
            state <= S_APPEND;
          end
        end
        S_APPEND: begin
          count       <= count + 1'b1;
          done        <= 1'b1;
          entry_index <= count[IDX_W-1:0];
          status      <= ST_ADDED;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/pdct_checker.sv =====
// Port-level checker for the pair dedup chain table unit, with its bind.
// Depends on pdct_pkg and pair_dedup_chain_table_unit_macros.svh.
`include "pair_dedup_chain_table_unit_macros.svh"

module pdct_checker #(
  parameter int DEPTH = pdct_pkg::DEPTH_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     start,
  input logic                     busy,
  input logic                     done,
  input logic [$clog2(DEPTH)-1:0] entry_index,
  input pdct_pkg::status_t        status
);

  import pdct_pkg::*;

  // A taken beat is either still in progress or answered next cycle.
  `PDCT_ASSERT_NEXT(a_beat_answered, start && !busy, busy || done)

  // A result never appears without a beat or work in progress before it.
  `PDCT_ASSERT_SAME(a_no_stray_result, done, $past(busy) || $past(start))

  // A bad head is answered straight from idle, with index zero.
  `PDCT_ASSERT_SAME(a_bad_head_quick, done && (status == ST_BAD_HEAD),
                    !$past(busy) && (entry_index == '0))

  // A full table reports index zero.
  `PDCT_ASSERT_SAME(a_full_index, done && (status == ST_FULL), entry_index == '0)

endmodule

bind pair_dedup_chain_table_unit pdct_checker #(.DEPTH(DEPTH)) u_pdct_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .entry_index (entry_index),
  .status      (status)
);
